### rtl/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg
// Shared widths, register indexes and the result word layout of the step detector.
// ----------------------------------------------------------------------------
package asd_pkg;

  localparam int unsigned AxisW  = 12;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DevW   = 62;
  localparam int unsigned MaxW   = 61;
  localparam int unsigned CfgW   = 62;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_BASE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_FALLOFF = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ABS_THRESHOLD   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_ENV_RATIO       = 2'd3;

  localparam logic [7:0] EnvKeep = 8'd230;
  localparam logic [7:0] EnvTake = 8'd26;

  // Packed output word, highest field first
  typedef struct packed {
    logic signed [DevW-1:0] deviance_out;
    logic                   new_step;
    logic                   is_step;
    logic [15:0]            step_cnt;
  } asd_result_t;

endpackage

### rtl/asd_ram.sv
// ----------------------------------------------------------------------------
// asd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/accel_step_detector.sv
// ----------------------------------------------------------------------------
// accel_step_detector
// Step counter driven by a stream of 3-axis accelerometer samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry one sample (x, y, z, timestamp). Each accepted word gives
//   exactly one output word: step count, step flag, new-step flag and the
//   cubed deviance.
//   One sample at a time is worked on. The ring sum is rebuilt from the sample
//   RAM one entry a cycle; each sample then passes the mean, dot, square and
//   cube steps, a read/write walk of the held-maximum RAM, the envelope and the
//   step test before its output word, and a new word is taken only once the
//   previous result has been handed to the output register.
//   The output register frees the core: the next sample is taken while a
//   result still waits, and only a second finished result stalls behind it.
//   After reset a clearing pass zeroes every entry of the sample RAM
//   before the first word is accepted; the held-maximum slots are cleared by
//   valid bits. Configuration writes are taken at any time but are meant for
//   idle periods.
// ----------------------------------------------------------------------------
module accel_step_detector #(
  parameter int unsigned RING_DEPTH = 8,
  parameter int unsigned MAX_SLOTS  = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // tdata: accel_x[11:0], accel_y[23:12], accel_z[35:24], time_ms[67:36], pad
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [71:0]                 in_tdata,
  // tdata: step_cnt[15:0], is_step[16], new_step[17], deviance_out[79:18]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [79:0]                 out_tdata,
  input  logic                        cfg_we,
  input  logic [asd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [asd_pkg::CfgW-1:0]    cfg_wdata
);
  import asd_pkg::*;

  localparam int unsigned RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned SumW = AxisW + RW + 1;
  localparam int unsigned SlotBits = MaxW + TimeW;
  // Mean by reciprocal multiplication on the biased (non-negative) sum
  localparam int unsigned NW = AxisW + RW;
  localparam int unsigned RcpSh = NW + RW;
  localparam int unsigned RcpW = NW + 2;
  localparam int unsigned RcpMul = (1 << RcpSh) / RING_DEPTH + 1;
  localparam int unsigned MeanBias = 1 << (AxisW - 1);
  // |dot| < 2^25, so dot >>> 6 fits 20 signed bits
  localparam int unsigned DW = 20;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SUM   = 4'd2;
  localparam logic [3:0] ST_MEAN  = 4'd3;
  localparam logic [3:0] ST_DOT   = 4'd4;
  localparam logic [3:0] ST_SQ    = 4'd5;
  localparam logic [3:0] ST_CUBE  = 4'd6;
  localparam logic [3:0] ST_SLOTR = 4'd7;
  localparam logic [3:0] ST_SLOTW = 4'd8;
  localparam logic [3:0] ST_ENV   = 4'd9;
  localparam logic [3:0] ST_TEST  = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  // Configuration registers
  logic [15:0]     tmo_base_r;
  logic [11:0]     tmo_fall_r;
  logic [CfgW-1:0] abs_thr_r;
  logic [7:0]      env_ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_base_r  <= 16'd500;
      tmo_fall_r  <= 12'd50;
      abs_thr_r   <= CfgW'(1000000);
      env_ratio_r <= 8'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT_BASE:    tmo_base_r  <= cfg_wdata[15:0];
        CFG_TIMEOUT_FALLOFF: tmo_fall_r  <= cfg_wdata[11:0];
        CFG_ABS_THRESHOLD:   abs_thr_r   <= cfg_wdata;
        CFG_ENV_RATIO:       env_ratio_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic [3:0]  state_r, state_nxt;
  logic [RW:0] cnt_r, cnt_nxt;
  logic [RW-1:0] wp_r;
  logic [SW:0] slot_r;

  logic signed [AxisW-1:0] sx_r, sy_r, sz_r;
  logic [TimeW-1:0]        t_r;
  logic signed [SumW-1:0]  sumx_r, sumy_r, sumz_r;
  logic signed [AxisW-1:0] mx_r, my_r, mz_r;
  logic signed [40:0]      dot_r;
  logic signed [DW-1:0]    d_r;
  logic signed [2*DW-1:0]  sq_r;
  logic signed [DevW-1:0]  dev_r;
  logic [16:0]             tmo_r;
  logic [MaxW-1:0]         tail_max_r;
  logic [MAX_SLOTS-1:0]    slot_vld_r;
  logic [MaxW-1:0]         env_r;
  logic [MaxW-1:0]         hmax0_r;
  logic                    prev_r;
  logic [15:0]             steps_r;
  logic                    ostep_r, onew_r;

  // Sample ring memory
  logic                 ring_we;
  logic [RW-1:0]        ring_waddr, ring_raddr;
  logic [3*AxisW-1:0]   ring_wdata, ring_rdata;

  asd_ram #(.WIDTH(3*AxisW), .DEPTH(RING_DEPTH)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  // Held maximum memory: {max, time}
  logic                slot_we;
  logic [SW-1:0]       slot_waddr, slot_raddr;
  logic [SlotBits-1:0] slot_wdata, slot_rdata;

  asd_ram #(.WIDTH(SlotBits), .DEPTH(MAX_SLOTS)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  logic out_free;
  assign out_free  = !out_tvalid || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // Slots are walked from last to first so the later maximum is known
  logic [SW-1:0] sidx;
  assign sidx = slot_r[SW-1:0];

  logic [MaxW-1:0]  cur_max;
  logic [TimeW-1:0] cur_time;
  assign cur_max  = slot_vld_r[sidx] ? slot_rdata[SlotBits-1:TimeW] : '0;
  assign cur_time = slot_vld_r[sidx] ? slot_rdata[TimeW-1:0] : '0;

  // Timeout of slot sidx = max(0, base - sidx*falloff)
  logic [16:0] slot_tmo;
  logic [20:0] fall_prod;
  assign fall_prod = 21'(sidx) * 21'(tmo_fall_r);
  assign slot_tmo  = (21'(tmo_base_r) > fall_prod) ? 17'(21'(tmo_base_r) - fall_prod) : '0;

  logic dev_pos;
  assign dev_pos = !dev_r[DevW-1] && (dev_r != '0);

  logic             upd_new, upd_exp;
  logic [MaxW-1:0]  new_max;
  logic [TimeW-1:0] elapsed;
  assign elapsed = t_r - cur_time;
  assign upd_new = dev_pos && (MaxW'(dev_r) > cur_max);
  assign upd_exp = !upd_new && (elapsed > TimeW'(tmo_r));
  assign new_max = upd_new ? MaxW'(dev_r) : (upd_exp ? tail_max_r : cur_max);

  // Floor mean: bias the sum to non-negative, multiply by the reciprocal,
  // then take the bias back off; exact for any RING_DEPTH
  function automatic logic signed [AxisW-1:0] floor_mean(input logic signed [SumW-1:0] s);
    logic [NW-1:0]      n;
    logic [NW+RcpW-1:0] p;
    n = NW'(s + $signed(SumW'(RING_DEPTH << (AxisW - 1))));
    p = (NW+RcpW)'(n) * (NW+RcpW)'(RcpMul);
    return AxisW'(p >> RcpSh) - AxisW'(MeanBias);
  endfunction

  logic signed [AxisW:0] dx, dy, dz;
  assign dx = {sx_r[AxisW-1], sx_r} - {mx_r[AxisW-1], mx_r};
  assign dy = {sy_r[AxisW-1], sy_r} - {my_r[AxisW-1], my_r};
  assign dz = {sz_r[AxisW-1], sz_r} - {mz_r[AxisW-1], mz_r};

  logic signed [DW-1:0] d_w;
  assign d_w = DW'(dot_r >>> 6);

  logic [MaxW+8:0] env_sum;
  assign env_sum = (MaxW+9)'(env_r) * EnvKeep + (MaxW+9)'(hmax0_r) * EnvTake;

  logic [MaxW+8:0] env_scaled;
  logic [MaxW+8:0] dev_scaled;
  assign env_scaled = (MaxW+9)'(env_r) * (MaxW+9)'(env_ratio_r);
  assign dev_scaled = (MaxW+9)'({dev_r, 4'b0});

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ring_we    = 1'b0;
    ring_waddr = wp_r;
    ring_wdata = {sz_r, sy_r, sx_r};
    ring_raddr = cnt_r[RW-1:0];
    slot_we    = 1'b0;
    slot_waddr = sidx;
    slot_wdata = {new_max, upd_new ? t_r : cur_time};
    slot_raddr = sidx;
    unique case (state_r)
      ST_CLEAR: begin
        ring_we    = 1'b1;
        ring_waddr = cnt_r[RW-1:0];
        ring_wdata = '0;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == (RW+1)'(RING_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        // new sample goes into the ring as it is taken
        ring_we    = in_tvalid;
        ring_wdata = in_tdata[3*AxisW-1:0];
        if (in_tvalid) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (RW+1)'(RING_DEPTH)) state_nxt = ST_MEAN;
      end
      ST_MEAN: state_nxt = ST_DOT;
      ST_DOT:  state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_CUBE;
      ST_CUBE: state_nxt = ST_SLOTR;
      ST_SLOTR: state_nxt = ST_SLOTW;
      ST_SLOTW: begin
        slot_we = 1'b1;
        state_nxt = (slot_r == '0) ? ST_ENV : ST_SLOTR;
      end
      ST_ENV:  state_nxt = ST_TEST;
      ST_TEST: state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      cnt_r      <= '0;
      wp_r       <= '0;
      slot_vld_r <= '0;
      env_r      <= '0;
      prev_r     <= 1'b0;
      steps_r    <= '0;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == ST_SLOTW) slot_vld_r[sidx] <= 1'b1;
      if (state_r == ST_ENV) env_r <= MaxW'(env_sum >> 8);
      if (state_r == ST_DONE && out_free) begin
        out_tvalid <= 1'b1;
        prev_r     <= ostep_r;
        if (onew_r) steps_r <= steps_r + 16'd1;
        wp_r <= (wp_r == RW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end else if (out_tvalid && out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        sx_r <= in_tdata[AxisW-1:0];
        sy_r <= in_tdata[2*AxisW-1:AxisW];
        sz_r <= in_tdata[3*AxisW-1:2*AxisW];
        t_r  <= in_tdata[3*AxisW+TimeW-1:3*AxisW];
        sumx_r <= '0;
        sumy_r <= '0;
        sumz_r <= '0;
      end
      ST_SUM: begin
        // read data of the previous cycle's address
        if (cnt_r != '0) begin
          sumx_r <= sumx_r + SumW'($signed(ring_rdata[AxisW-1:0]));
          sumy_r <= sumy_r + SumW'($signed(ring_rdata[2*AxisW-1:AxisW]));
          sumz_r <= sumz_r + SumW'($signed(ring_rdata[3*AxisW-1:2*AxisW]));
        end
      end
      ST_MEAN: begin
        mx_r <= floor_mean(sumx_r);
        my_r <= floor_mean(sumy_r);
        mz_r <= floor_mean(sumz_r);
      end
      ST_DOT:  dot_r <= 41'(mx_r * dx) + 41'(my_r * dy) + 41'(mz_r * dz);
      ST_SQ: begin
        d_r  <= d_w;
        sq_r <= d_w * d_w;
      end
      ST_CUBE: begin
        dev_r      <= sq_r * d_r;
        slot_r     <= (SW+1)'(MAX_SLOTS - 1);
        tail_max_r <= '0;
      end
      ST_SLOTR: tmo_r <= slot_tmo;
      ST_SLOTW: begin
        // largest pre-update value of this and later slots
        if (cur_max > tail_max_r) tail_max_r <= cur_max;
        if (sidx == '0) hmax0_r <= new_max;
        slot_r <= slot_r - 1'b1;
      end
      ST_TEST: begin
        ostep_r <= (CfgW'(env_r) > abs_thr_r) && dev_pos && (env_scaled < dev_scaled);
        onew_r  <= (CfgW'(env_r) > abs_thr_r) && dev_pos && (env_scaled < dev_scaled) &&
                   !prev_r;
      end
      default: ;
    endcase
  end

  // Result word
  asd_result_t res_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      res_r.step_cnt     <= onew_r ? steps_r + 16'd1 : steps_r;
      res_r.is_step      <= ostep_r;
      res_r.new_step     <= onew_r;
      res_r.deviance_out <= dev_r;
    end
  end
  assign out_tdata = res_r;

endmodule

### rtl/asd_checker.sv
// ----------------------------------------------------------------------------
// asd_checker
// Port-level checks on the step detector, bound to the top level.
// ----------------------------------------------------------------------------
module asd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // Stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // A new step is always a step
  a_new_is_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[17] || out_tdata[16]))
    else $error("new_step without is_step");

  // No input taken during the cycle after one was taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted back to back");

  // Step count moves only with a new step
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready ##1 out_tvalid && !out_tdata[17] && $changed(out_tdata)
    |-> out_tdata[15:0] == $past(out_tdata[15:0]) || $past(out_tvalid) == 1'b0)
    else $error("step count moved without a new step");

endmodule

bind accel_step_detector asd_checker u_asd_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

### dv/tb_accel_step_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_step_detector
// Self-checking bench for the accelerometer step counter. Samples are streamed
// in under random back-pressure, an in-bench model of the ring mean, deviance
// cube, held-peak slots, envelope and step edge predicts every output word,
// and the monitor compares each one field by field.
// ----------------------------------------------------------------------------
module tb_accel_step_detector;
  import asd_pkg::*;

  localparam int RING = 8;
  localparam int SLOTS = 4;

  typedef struct packed {
    logic [31:0] time_ms;
    logic signed [11:0] z;
    logic signed [11:0] y;
    logic signed [11:0] x;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [71:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_wdata = '0;

  accel_step_detector dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  int ring_x[RING], ring_y[RING], ring_z[RING];
  int wr_slot;
  logic [63:0] peak[SLOTS];
  logic [31:0] peak_time[SLOTS];
  logic [63:0] envelope;
  bit last_step;
  logic [15:0] steps;
  logic [15:0] hold_base = 16'd500;
  logic [11:0] hold_falloff = 12'd50;
  logic [61:0] level_floor = 62'd1000000;
  logic [7:0] ratio = 8'd32;

  sample_t pending_samples[$];
  asd_result_t expected_words[$];
  int send_idle_pct, recv_idle_pct;
  int mismatches, words_checked, samples_sent;
  bit in_run;

  function automatic int div_floor8(int a);
    return a >>> 3;
  endfunction

  // Works out the output word for one sample and advances the model state
  function automatic asd_result_t predict_step(sample_t s);
    asd_result_t r;
    int sx, sy, sz, mx, my, mz;
    longint dot, d, dev;
    logic [31:0] tmo;
    logic [63:0] best;
    bit stp;
    sx = s.x; sy = s.y; sz = s.z;
    ring_x[wr_slot] = sx; ring_y[wr_slot] = sy; ring_z[wr_slot] = sz;
    mx = 0; my = 0; mz = 0;
    for (int i = 0; i < RING; i++) begin
      mx += ring_x[i]; my += ring_y[i]; mz += ring_z[i];
    end
    mx = div_floor8(mx); my = div_floor8(my); mz = div_floor8(mz);
    dot = longint'(mx) * (sx - mx) + longint'(my) * (sy - my) + longint'(mz) * (sz - mz);
    d = dot >>> 6;
    dev = d * d * d;
    tmo = hold_base;
    for (int i = 0; i < SLOTS; i++) begin
      if (dev > 0 && 64'(dev) > peak[i]) begin
        peak[i] = 64'(dev);
        peak_time[i] = s.time_ms;
      end else if (32'(s.time_ms - peak_time[i]) > tmo) begin
        best = 0;
        for (int j = i + 1; j < SLOTS; j++) if (peak[j] > best) best = peak[j];
        peak[i] = best;
      end
      tmo = (tmo > hold_falloff) ? tmo - hold_falloff : 0;
    end
    envelope = (envelope * 230 + peak[0] * 26) >> 8;
    stp = envelope > level_floor && dev > 0 && envelope * ratio < (64'(dev) << 4);
    r.new_step = stp && !last_step;
    if (r.new_step) steps++;
    last_step = stp;
    wr_slot = (wr_slot + 1) % RING;
    r.step_cnt = steps;
    r.is_step = stp;
    r.deviance_out = dev[61:0];
    return r;
  endfunction

  // Driver: presents queued samples, holding each word until it is taken
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      expected_words.push_back(predict_step(sample_t'(in_tdata[67:0])));
      samples_sent++;
    end
    if (!in_tvalid || in_tready) begin
      if (in_run && pending_samples.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_tdata <= {4'b0, pending_samples.pop_front()};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each output word against the oldest prediction
  always @(posedge clk) begin
    asd_result_t got, exp_w;
    if (out_tvalid && out_tready) begin
      got = asd_result_t'(out_tdata);
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", out_tdata);
      end else begin
        exp_w = expected_words.pop_front();
        if (got.step_cnt !== exp_w.step_cnt || got.is_step !== exp_w.is_step ||
            got.new_step !== exp_w.new_step || got.deviance_out !== exp_w.deviance_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: exp cnt=%0d step=%b new=%b dev=%0d got cnt=%0d step=%b new=%b dev=%0d",
                     words_checked, exp_w.step_cnt, exp_w.is_step, exp_w.new_step,
                     exp_w.deviance_out, got.step_cnt, got.is_step, got.new_step,
                     got.deviance_out);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TIMEOUT_BASE:    hold_base = val[15:0];
      CFG_TIMEOUT_FALLOFF: hold_falloff = val[11:0];
      CFG_ABS_THRESHOLD:   level_floor = val[61:0];
      CFG_ENV_RATIO:       ratio = val[7:0];
      default: ;
    endcase
  endtask

  task automatic push_sample(int x, int y, int z, logic [31:0] t);
    sample_t s;
    s.x = x[11:0]; s.y = y[11:0]; s.z = z[11:0]; s.time_ms = t;
    pending_samples.push_back(s);
  endtask

  // Runs queued samples to completion, then lets the block settle
  task automatic drain_phase();
    in_run = 1'b1;
    while (pending_samples.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    in_run = 1'b0;
    repeat (40) @(posedge clk);
  endtask

  // Walking-gait samples: a bias on one axis with a swing and time advancing, one in ten fully random
  task automatic queue_gait(int n, int amp, int step_ms, inout logic [31:0] t);
    int ph;
    for (int i = 0; i < n; i++) begin
      ph = i % 8;
      t += $urandom_range(step_ms);
      if ($urandom_range(9) == 0)
        push_sample($urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
                    $urandom_range(4095) - 2048, $urandom);
      else
        push_sample($urandom_range(200) - 100 + ((ph < 2) ? amp : -amp / 4),
                    $urandom_range(200) - 100 + ((ph < 2) ? amp : 0),
                    1000 + $urandom_range(amp) - amp / 2, t);
    end
  endtask

  initial begin
    logic [31:0] clock_ms;
    for (int i = 0; i < RING; i++) begin
      ring_x[i] = 0; ring_y[i] = 0; ring_z[i] = 0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      peak[i] = 0; peak_time[i] = 0;
    end
    wr_slot = 0; envelope = 0; last_step = 0; steps = 0;
    mismatches = 0; words_checked = 0; samples_sent = 0; in_run = 0;
    send_idle_pct = 24; recv_idle_pct = 80;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: field extremes, sign patterns, timestamp wrap, bit toggles
    write_reg(CFG_TIMEOUT_BASE, 62'd500);
    write_reg(CFG_ENV_RATIO, 62'd32);
    push_sample(2047, 2047, 2047, 32'd0);
    push_sample(-2048, -2048, -2048, 32'd1);
    push_sample(2047, -2048, 2047, 32'hFFFF_FFFF);
    push_sample(0, 0, 0, 32'hAAAA_AAAA);
    push_sample(-1, -1, -1, 32'h5555_5555);
    push_sample(1365, -1366, 682, 32'hFFFF_FFF0);
    push_sample(-1366, 1365, -683, 32'h0000_0010);
    for (int i = 0; i < 8; i++) push_sample(2047, 2047, 2047, 32'd20 + i);
    push_sample(-2048, -2048, -2048, 32'd40);
    push_sample(2047, 2047, -2048, 32'd2000);
    push_sample(0, 0, 2047, 32'd2001);
    drain_phase();

    // Extremes of configuration
    write_reg(CFG_TIMEOUT_BASE, 62'd0);
    write_reg(CFG_TIMEOUT_FALLOFF, 62'd4095);
    write_reg(CFG_ABS_THRESHOLD, 62'h3FFF_FFFF_FFFF_FFFF);
    write_reg(CFG_ENV_RATIO, 62'd255);
    clock_ms = 32'd5000;
    queue_gait(40, 1500, 30, clock_ms);
    drain_phase();

    write_reg(CFG_TIMEOUT_BASE, 62'd65535);
    write_reg(CFG_TIMEOUT_FALLOFF, 62'd0);
    write_reg(CFG_ABS_THRESHOLD, 62'd0);
    write_reg(CFG_ENV_RATIO, 62'd0);
    queue_gait(60, 1800, 40, clock_ms);
    drain_phase();

    // Main random phases with the idling schedule
    write_reg(CFG_TIMEOUT_BASE, 62'd300);
    write_reg(CFG_TIMEOUT_FALLOFF, 62'd80);
    write_reg(CFG_ABS_THRESHOLD, 62'd1000);
    write_reg(CFG_ENV_RATIO, 62'd20);
    queue_gait(180, 1600, 60, clock_ms);
    drain_phase();

    send_idle_pct = 80; recv_idle_pct = 24;
    write_reg(CFG_ABS_THRESHOLD, 62'd100000);
    write_reg(CFG_ENV_RATIO, 62'd16);
    queue_gait(180, 1200, 80, clock_ms);
    drain_phase();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(CFG_TIMEOUT_BASE, 62'd500);
    write_reg(CFG_TIMEOUT_FALLOFF, 62'd50);
    write_reg(CFG_ABS_THRESHOLD, 62'd1000000);
    write_reg(CFG_ENV_RATIO, 62'd32);
    queue_gait(170, 2000, 50, clock_ms);
    drain_phase();

    $display("Covered %0d samples and %0d output words over six register settings,",
             samples_sent, words_checked);
    $display("ending with %0d steps counted and %0d mismatches.", steps, mismatches);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("accel_step_detector verification clean");
    else
      $display("accel_step_detector verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("accel_step_detector verification failed");
    $finish;
  end

endmodule
